[rtl/core/vrst_pkg.sv]
// ----------------------------------------------------------------------------
// vrst_pkg
// Shared types and constants of the video register / scroll timing unit.
// ----------------------------------------------------------------------------
package vrst_pkg;

    localparam int SPRITE_MEM_BYTES = 256;

    localparam int ADDR_W = 15;
    localparam int LINE_W = 10;
    localparam int DOT_W  = 9;

    typedef enum logic [1:0] {
        OP_DOT   = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NMI   = 2'd3
    } t_op;

    // CPU-visible register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_SPR_ADDR = 3'd3;
    localparam logic [2:0] REG_SPR_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    typedef struct packed {
        t_op        op;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] vram_read_data;
        logic       immediate_read;
    } t_item;

    typedef struct packed {
        logic                     accepted;
        logic [DOT_W-1:0]         dot_number;
        logic signed [LINE_W-1:0] line_number;
        logic                     in_vblank;
        logic                     nmi_pending;
        logic [7:0]               vram_write_data;
        logic                     vram_write;
        logic                     vram_read;
        logic [ADDR_W-1:0]        vram_address;
        logic [7:0]               read_data;
    } t_result;

    // sprite memory access from the register core
    typedef struct packed {
        logic       we;
        logic [7:0] wr_addr;
        logic [7:0] wr_data;
        logic [7:0] rd_addr;
    } t_spr_req;

endpackage

[rtl/core/vrst_spr_mem.sv]
// ----------------------------------------------------------------------------
// vrst_spr_mem
// Sprite memory: one write port, one registered read port, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vrst_spr_mem #(
    parameter int SPRITE_MEM_BYTES = vrst_pkg::SPRITE_MEM_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrst_pkg::t_spr_req i_req,
    output logic [7:0]        o_rd_data
);

    localparam int IDX_W = $clog2(SPRITE_MEM_BYTES);

    // byte address modulo memory size; at most three subtractions for >= 64
    function automatic logic [IDX_W-1:0] f_index(input logic [7:0] a);
        logic [8:0] v;
        v = {1'b0, a};
        for (int k = 0; k < 4; k++) begin
            if (v >= 9'(SPRITE_MEM_BYTES)) begin
                v = v - 9'(SPRITE_MEM_BYTES);
            end
        end
        return v[IDX_W-1:0];
    endfunction

    logic [7:0]                  r_mem [SPRITE_MEM_BYTES];
    logic [SPRITE_MEM_BYTES-1:0] r_valid;
    logic [7:0]                  r_rdata;
    logic                        r_rvalid;
    logic [IDX_W-1:0]            wr_idx;
    logic [IDX_W-1:0]            rd_idx;

    assign wr_idx = f_index(i_req.wr_addr);
    assign rd_idx = f_index(i_req.rd_addr);

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[wr_idx] <= i_req.wr_data;
        end
        if (i_req.we && (wr_idx == rd_idx)) begin
            r_rdata <= i_req.wr_data;
        end else begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_req.we) begin
                r_valid[wr_idx] <= 1'b1;
            end
            r_rvalid <= r_valid[rd_idx] || (i_req.we && (wr_idx == rd_idx));
        end
    end

    assign o_rd_data = r_rvalid ? r_rdata : 8'h00;

endmodule

[rtl/core/vrst_core.sv]
// ----------------------------------------------------------------------------
// vrst_core
// Register file, scroll address logic and raster counters. Updates the
// state and forms one result for the item presented while i_fire is high.
// ----------------------------------------------------------------------------
module vrst_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  vrst_pkg::t_item    i_item,
    input  logic [7:0]         i_spr_rd_data,
    output vrst_pkg::t_spr_req o_spr_req,
    output vrst_pkg::t_result  o_res
);

    localparam int AW = vrst_pkg::ADDR_W;
    localparam int LW = vrst_pkg::LINE_W;
    localparam int DW = vrst_pkg::DOT_W;

    localparam logic signed [LW-1:0] LINE_PRE    = -10'sd1;
    localparam logic signed [LW-1:0] LINE_FIRST  = 10'sd0;
    localparam logic signed [LW-1:0] LINE_VIS_END = 10'sd239;
    localparam logic signed [LW-1:0] LINE_VBLANK = 10'sd241;
    localparam logic signed [LW-1:0] LINE_LAST   = 10'sd260;
    localparam logic [DW-1:0] DOT_LAST      = 9'd340;
    localparam logic [DW-1:0] DOT_Y_INC     = 9'd256;
    localparam logic [DW-1:0] DOT_X_COPY    = 9'd257;
    localparam logic [DW-1:0] DOT_PREF_LO   = 9'd321;
    localparam logic [DW-1:0] DOT_PREF_HI   = 9'd337;
    localparam logic [DW-1:0] DOT_Y_COPY_LO = 9'd280;
    localparam logic [DW-1:0] DOT_Y_COPY_HI = 9'd304;
    localparam logic [AW-1:0] MASK_X        = 15'h041F;
    localparam logic [AW-1:0] MASK_Y        = 15'h7BE0;

    function automatic logic [AW-1:0] f_x_inc(input logic [AW-1:0] a);
        if (a[4:0] == 5'd31) begin
            return {a[14:5], 5'd0} ^ 15'h0400;
        end
        return a + 15'd1;
    endfunction

    function automatic logic [AW-1:0] f_y_inc(input logic [AW-1:0] a);
        logic [AW-1:0] t;
        logic [4:0]    cy;
        if (a[14:12] != 3'd7) begin
            return a + 15'h1000;
        end
        t  = {3'd0, a[11:0]};
        cy = t[9:5];
        if (cy == 5'd29) begin
            cy = 5'd0;
            t  = t ^ 15'h0800;
        end else if (cy == 5'd31) begin
            cy = 5'd0;
        end else begin
            cy = cy + 5'd1;
        end
        t[9:5] = cy;
        return t;
    endfunction

    logic [7:0]           r_ctrl, n_ctrl;
    logic [7:0]           r_mask, n_mask;
    logic                 r_vblank, n_vblank;   // status bit 7, the only one kept
    logic [7:0]           r_spr_addr, n_spr_addr;
    logic [AW-1:0]        r_cur, n_cur;
    logic [AW-1:0]        r_tmp, n_tmp;
    logic [2:0]           r_fine_x, n_fine_x;
    logic                 r_first, n_first;
    logic [7:0]           r_buf, n_buf;
    logic                 r_nmi, n_nmi;
    logic signed [LW-1:0] r_line, n_line;
    logic [DW-1:0]        r_dot, n_dot;

    logic          rendering;
    logic          x_inc_dot;
    logic [AW-1:0] a_x, a_y, a_cx, a_cy;
    logic          spr_we;
    vrst_pkg::t_result res;

    assign rendering = (r_mask[4] || r_mask[3]);
    assign x_inc_dot = (((r_dot >= 9'd2) && (r_dot <= DOT_X_COPY)) ||
                        ((r_dot >= DOT_PREF_LO) && (r_dot <= DOT_PREF_HI))) &&
                       (r_dot[2:0] == 3'd0);

    // scroll chain for a dot tick: x increment, y increment, copies
    always_comb begin
        a_x  = x_inc_dot ? f_x_inc(r_cur) : r_cur;
        a_y  = (r_dot == DOT_Y_INC) ? f_y_inc(a_x) : a_x;
        a_cx = (r_dot == DOT_X_COPY) ? ((a_y & ~MASK_X) | (r_tmp & MASK_X)) : a_y;
        a_cy = ((r_line == LINE_PRE) && (r_dot >= DOT_Y_COPY_LO) &&
                (r_dot <= DOT_Y_COPY_HI)) ? ((a_cx & ~MASK_Y) | (r_tmp & MASK_Y)) : a_cx;
    end

    always_comb begin
        n_ctrl     = r_ctrl;
        n_mask     = r_mask;
        n_vblank   = r_vblank;
        n_spr_addr = r_spr_addr;
        n_cur      = r_cur;
        n_tmp      = r_tmp;
        n_fine_x   = r_fine_x;
        n_first    = r_first;
        n_buf      = r_buf;
        n_nmi      = r_nmi;
        n_line     = r_line;
        n_dot      = r_dot;
        spr_we     = 1'b0;
        res        = '0;

        case (i_item.op)
            vrst_pkg::OP_DOT: begin
                if ((r_line == LINE_FIRST) && (r_dot == '0)) begin
                    n_dot = 9'd1;   // odd skip of the first dot
                end else begin
                    if ((r_line == LINE_PRE) && (r_dot == 9'd1)) begin
                        n_vblank = 1'b0;
                    end else if ((r_line == LINE_VBLANK) && (r_dot == 9'd1)) begin
                        n_vblank = 1'b1;
                        if (r_ctrl[7]) begin
                            n_nmi = 1'b1;
                        end
                    end
                    if (rendering && (r_line <= LINE_VIS_END)) begin
                        n_cur = a_cy;
                    end
                    if (r_dot == DOT_LAST) begin
                        n_dot  = '0;
                        n_line = (r_line == LINE_LAST) ? LINE_PRE : r_line + 10'sd1;
                    end else begin
                        n_dot = r_dot + 9'd1;
                    end
                end
            end
            vrst_pkg::OP_READ: begin
                case (i_item.reg_select)
                    vrst_pkg::REG_CTRL:     res.read_data = r_ctrl;
                    vrst_pkg::REG_MASK:     res.read_data = r_mask;
                    vrst_pkg::REG_STATUS: begin
                        res.read_data = {r_vblank, 2'b00, r_buf[4:0]};
                        n_vblank      = 1'b0;
                        n_first       = 1'b1;
                    end
                    vrst_pkg::REG_SPR_DATA: res.read_data = i_spr_rd_data;
                    vrst_pkg::REG_DATA: begin
                        res.vram_address = r_cur;
                        res.vram_read    = 1'b1;
                        res.read_data    = i_item.immediate_read ? i_item.vram_read_data
                                                                 : r_buf;
                        n_buf            = i_item.vram_read_data;
                        n_cur            = r_cur + (r_ctrl[2] ? 15'h0020 : 15'h0001);
                    end
                    default: ;
                endcase
            end
            vrst_pkg::OP_WRITE: begin
                res.accepted = 1'b1;
                case (i_item.reg_select)
                    vrst_pkg::REG_CTRL: begin
                        n_ctrl        = i_item.write_data;
                        n_tmp[11:10]  = i_item.write_data[1:0];
                    end
                    vrst_pkg::REG_MASK:     n_mask = i_item.write_data;
                    vrst_pkg::REG_SPR_ADDR: n_spr_addr = i_item.write_data;
                    vrst_pkg::REG_SPR_DATA: begin
                        spr_we     = 1'b1;
                        n_spr_addr = r_spr_addr + 8'd1;
                    end
                    vrst_pkg::REG_SCROLL: begin
                        if (r_first) begin
                            n_fine_x   = i_item.write_data[2:0];
                            n_tmp[4:0] = i_item.write_data[7:3];
                        end else begin
                            n_tmp[14:12] = i_item.write_data[2:0];
                            n_tmp[9:5]   = i_item.write_data[7:3];
                        end
                        n_first = !r_first;
                    end
                    vrst_pkg::REG_ADDR: begin
                        if (r_first) begin
                            n_tmp = {1'b0, i_item.write_data[5:0], r_tmp[7:0]};
                        end else begin
                            n_tmp = {r_tmp[14:8], i_item.write_data};
                            n_cur = {r_tmp[14:8], i_item.write_data};
                        end
                        n_first = !r_first;
                    end
                    vrst_pkg::REG_DATA: begin
                        res.vram_address    = r_cur;
                        res.vram_write      = 1'b1;
                        res.vram_write_data = i_item.write_data;
                        n_cur               = r_cur + (r_ctrl[2] ? 15'h0020 : 15'h0001);
                    end
                    default: res.accepted = 1'b0;
                endcase
            end
            vrst_pkg::OP_NMI: n_nmi = i_item.write_data[0];
            default: ;
        endcase

        res.nmi_pending = n_nmi;
        res.in_vblank   = n_vblank;
        res.line_number = n_line;
        res.dot_number  = n_dot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_mask     <= '0;
            r_vblank   <= 1'b0;
            r_spr_addr <= '0;
            r_cur      <= '0;
            r_tmp      <= '0;
            r_fine_x   <= '0;
            r_first    <= 1'b1;
            r_buf      <= '0;
            r_nmi      <= 1'b0;
            r_line     <= '0;
            r_dot      <= '0;
        end else if (i_fire) begin
            r_ctrl     <= n_ctrl;
            r_mask     <= n_mask;
            r_vblank   <= n_vblank;
            r_spr_addr <= n_spr_addr;
            r_cur      <= n_cur;
            r_tmp      <= n_tmp;
            r_fine_x   <= n_fine_x;
            r_first    <= n_first;
            r_buf      <= n_buf;
            r_nmi      <= n_nmi;
            r_line     <= n_line;
            r_dot      <= n_dot;
        end
    end

    // read port tracks the sprite address the next item will see
    assign o_spr_req.we      = i_fire && spr_we;
    assign o_spr_req.wr_addr = r_spr_addr;
    assign o_spr_req.wr_data = i_item.write_data;
    assign o_spr_req.rd_addr = i_fire ? n_spr_addr : r_spr_addr;

    assign o_res = res;

endmodule

[rtl/core/video_register_scroll_timing_unit.sv]
// ----------------------------------------------------------------------------
// video_register_scroll_timing_unit
// Picture-processor register and scroll unit, stream wrapper.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_axis) carries one word per item: tuser is the operation
//   (dot tick, CPU register read, CPU register write, NMI flag write), tdata
//   carries the register number, the CPU byte, the video memory byte and the
//   immediate-read flag. Master channel (m_axis) returns exactly one result
//   word per item, in order.
//   Registered path: the word lands in the input register, and the result
//   register is loaded from it when the output can advance.
//   Throughput: 1 item per cycle while m_axis does not stall; all per-item work,
//   including the sprite memory read (prefetched at the address the next item
//   will use), fits in one pass.
//   Reset: all registers, counters and the write toggle return to their
//   power-up values; sprite memory reads as zero until written.
//   Stall: when m_axis_tready is low the result is held; one more item is
//   still taken into the input register if it is empty, then s_axis_tready
//   drops until the result is taken.
// ----------------------------------------------------------------------------
module video_register_scroll_timing_unit #(
    parameter int SPRITE_MEM_BYTES = vrst_pkg::SPRITE_MEM_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] reg_select, [10:3] write_data, [18:11] vram_read_data,
    // [19] immediate_read, [23:20] zero
    input  logic [23:0] i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] read_data, [22:8] vram_address, [23] vram_read, [24] vram_write,
    // [32:25] vram_write_data, [33] nmi_pending, [34] in_vblank,
    // [44:35] line_number, [53:45] dot_number, [54] accepted, [55] zero
    output logic [55:0] o_m_axis_tdata
);

    logic               r_in_valid;
    vrst_pkg::t_item    r_in;
    logic               r_out_valid;
    vrst_pkg::t_result  r_out;

    logic               advance;
    logic               fire;
    vrst_pkg::t_result  res;
    vrst_pkg::t_spr_req spr_req;
    logic [7:0]         spr_rd_data;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in.op             <= vrst_pkg::t_op'(i_s_axis_tuser);
            r_in.reg_select     <= i_s_axis_tdata[2:0];
            r_in.write_data     <= i_s_axis_tdata[10:3];
            r_in.vram_read_data <= i_s_axis_tdata[18:11];
            r_in.immediate_read <= i_s_axis_tdata[19];
        end
        if (fire) begin
            r_out <= res;
        end
    end

    vrst_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (r_in),
        .i_spr_rd_data (spr_rd_data),
        .o_spr_req     (spr_req),
        .o_res         (res)
    );

    vrst_spr_mem #(
        .SPRITE_MEM_BYTES (SPRITE_MEM_BYTES)
    ) u_spr_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (spr_req),
        .o_rd_data (spr_rd_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0,
                              r_out.accepted,
                              r_out.dot_number,
                              r_out.line_number,
                              r_out.in_vblank,
                              r_out.nmi_pending,
                              r_out.vram_write_data,
                              r_out.vram_write,
                              r_out.vram_read,
                              r_out.vram_address,
                              r_out.read_data};

endmodule

[tb/video_register_scroll_timing_unit_tb.sv]
// ----------------------------------------------------------------------------
// video_register_scroll_timing_unit_tb
// Self-checking bench for the register / scroll timing unit. A behavioral
// model of the registers, scroll address logic and raster counters predicts
// one result word per accepted input word; results are checked in order,
// field by field, under random source gaps and sink back-pressure.
// ----------------------------------------------------------------------------
module video_register_scroll_timing_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SCROLL_DOTS = 650;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [55:0] m_tdata;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    vrst_pkg::t_result bus_results_due[$];

    // model state
    logic [7:0]  ctrl_q, mask_q, status_q, oam_addr_q, rbuf_q;
    logic [7:0]  oam_q [vrst_pkg::SPRITE_MEM_BYTES];
    logic [14:0] vaddr_q, taddr_q;
    logic        toggle_q, nmi_q;
    int          line_q, dot_q;

    video_register_scroll_timing_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("video_register_scroll_timing_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Model: one step per accepted word
    // ------------------------------------------------------------------
    function automatic vrst_pkg::t_result step_register_unit(vrst_pkg::t_item it);
        vrst_pkg::t_result r;
        logic [4:0] cy;
        logic ren;
        r = '0;
        ren = (mask_q & 8'h18) != 8'h00;
        case (it.op)
            vrst_pkg::OP_DOT: begin
                if (line_q == 0 && dot_q == 0) begin
                    dot_q = 1;  // odd skip at the top of the frame
                end else begin
                    if (line_q == -1 && dot_q == 1) begin
                        status_q = status_q & 8'h1F;
                    end else if (line_q == 241 && dot_q == 1) begin
                        status_q[7] = 1'b1;
                        if (ctrl_q[7]) nmi_q = 1'b1;
                    end
                    if (line_q <= 239 && ren) begin
                        if (((dot_q >= 2 && dot_q <= 257) || (dot_q >= 321 && dot_q <= 337))
                            && (dot_q % 8) == 0) begin
                            if (vaddr_q[4:0] == 5'd31) begin
                                vaddr_q[4:0] = 5'd0;
                                vaddr_q[10] = ~vaddr_q[10];
                            end else begin
                                vaddr_q = vaddr_q + 15'd1;
                            end
                        end
                        if (dot_q == 256) begin
                            if (vaddr_q[14:12] != 3'd7) begin
                                vaddr_q[14:12] = vaddr_q[14:12] + 3'd1;
                            end else begin
                                vaddr_q[14:12] = 3'd0;
                                cy = vaddr_q[9:5];
                                if (cy == 5'd29) begin
                                    cy = 5'd0;
                                    vaddr_q[11] = ~vaddr_q[11];
                                end else if (cy == 5'd31) begin
                                    cy = 5'd0;  // attribute rows wrap without nametable flip
                                end else begin
                                    cy = cy + 5'd1;
                                end
                                vaddr_q[9:5] = cy;
                            end
                        end
                        if (dot_q == 257) begin
                            vaddr_q[10]  = taddr_q[10];
                            vaddr_q[4:0] = taddr_q[4:0];
                        end
                        if (line_q == -1 && dot_q >= 280 && dot_q <= 304) begin
                            vaddr_q[14:11] = taddr_q[14:11];
                            vaddr_q[9:5]   = taddr_q[9:5];
                        end
                    end
                    dot_q++;
                    if (dot_q >= 341) begin
                        dot_q = 0;
                        line_q = (line_q == 260) ? -1 : line_q + 1;
                    end
                end
            end
            vrst_pkg::OP_READ: begin
                case (it.reg_select)
                    vrst_pkg::REG_CTRL: r.read_data = ctrl_q;
                    vrst_pkg::REG_MASK: r.read_data = mask_q;
                    vrst_pkg::REG_STATUS: begin
                        r.read_data = {status_q[7:5], rbuf_q[4:0]};
                        status_q[7] = 1'b0;
                        toggle_q = 1'b1;
                    end
                    vrst_pkg::REG_SPR_DATA:
                        r.read_data = oam_q[oam_addr_q % vrst_pkg::SPRITE_MEM_BYTES];
                    vrst_pkg::REG_DATA: begin
                        r.vram_address = vaddr_q;
                        r.vram_read = 1'b1;
                        r.read_data = it.immediate_read ? it.vram_read_data : rbuf_q;
                        rbuf_q = it.vram_read_data;
                        vaddr_q = vaddr_q + (ctrl_q[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            vrst_pkg::OP_WRITE: begin
                r.accepted = 1'b1;
                case (it.reg_select)
                    vrst_pkg::REG_CTRL: begin
                        ctrl_q = it.write_data;
                        taddr_q[11:10] = it.write_data[1:0];
                    end
                    vrst_pkg::REG_MASK: mask_q = it.write_data;
                    vrst_pkg::REG_STATUS: r.accepted = 1'b0;
                    vrst_pkg::REG_SPR_ADDR: oam_addr_q = it.write_data;
                    vrst_pkg::REG_SPR_DATA: begin
                        oam_q[oam_addr_q % vrst_pkg::SPRITE_MEM_BYTES] = it.write_data;
                        oam_addr_q = oam_addr_q + 8'd1;
                    end
                    vrst_pkg::REG_SCROLL: begin
                        if (toggle_q) begin
                            taddr_q[4:0] = it.write_data[7:3];
                        end else begin
                            taddr_q[14:12] = it.write_data[2:0];
                            taddr_q[9:5]   = it.write_data[7:3];
                        end
                        toggle_q = ~toggle_q;
                    end
                    vrst_pkg::REG_ADDR: begin
                        if (toggle_q) begin
                            taddr_q[13:8] = it.write_data[5:0];
                            taddr_q[14] = 1'b0;
                        end else begin
                            taddr_q[7:0] = it.write_data;
                            vaddr_q = taddr_q;
                        end
                        toggle_q = ~toggle_q;
                    end
                    vrst_pkg::REG_DATA: begin
                        r.vram_address = vaddr_q;
                        r.vram_write = 1'b1;
                        r.vram_write_data = it.write_data;
                        vaddr_q = vaddr_q + (ctrl_q[2] ? 15'd32 : 15'd1);
                    end
                    default: ;
                endcase
            end
            default: nmi_q = it.write_data[0];
        endcase
        r.nmi_pending = nmi_q;
        r.in_vblank   = status_q[7];
        r.line_number = line_q[9:0];
        r.dot_number  = dot_q[8:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    task automatic send_item(input vrst_pkg::t_op op, input logic [2:0] sel,
                             input logic [7:0] wd, input logic [7:0] vin, input logic imm);
        vrst_pkg::t_item it;
        it.op = op;
        it.reg_select = sel;
        it.write_data = wd;
        it.vram_read_data = vin;
        it.immediate_read = imm;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {4'd0, imm, vin, wd, sel};
        s_tuser <= op;
        do @(posedge i_clk); while (!s_ready);
        bus_results_due.insert(bus_results_due.size(), step_register_unit(it));
    endtask

    task automatic send_random_fields(input vrst_pkg::t_op op);
        send_item(op, 3'($urandom_range(7)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (bus_results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Sink side and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic check_result(input vrst_pkg::t_result got);
        vrst_pkg::t_result want;
        if (bus_results_due.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending: %h", got));
        end else begin
            want = bus_results_due.pop_front();
            compare_field("read_data", 16'(got.read_data), 16'(want.read_data));
            compare_field("vram_address", 16'(got.vram_address), 16'(want.vram_address));
            compare_field("vram_read", 16'(got.vram_read), 16'(want.vram_read));
            compare_field("vram_write", 16'(got.vram_write), 16'(want.vram_write));
            compare_field("vram_write_data", 16'(got.vram_write_data),
                          16'(want.vram_write_data));
            compare_field("nmi_pending", 16'(got.nmi_pending), 16'(want.nmi_pending));
            compare_field("in_vblank", 16'(got.in_vblank), 16'(want.in_vblank));
            compare_field("line_number", 16'(got.line_number), 16'(want.line_number));
            compare_field("dot_number", 16'(got.dot_number), 16'(want.dot_number));
            compare_field("accepted", 16'(got.accepted), 16'(want.accepted));
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && m_valid && m_ready) check_result(vrst_pkg::t_result'(m_tdata[54:0]));
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_state_reads();
        for (int r = 0; r < 8; r++) send_item(vrst_pkg::OP_READ, r[2:0], 8'h00, 8'hFF, 1'b0);
    endtask

    task automatic test_register_writes();
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_STATUS, 8'hFF, 8'h00, 1'b0);   // ignored
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_SPR_ADDR, 8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_SPR_DATA, 8'hA5, 8'h00, 1'b0);
        // sprite address wraps to 0
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_SPR_DATA, 8'h5A, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_READ,  vrst_pkg::REG_SPR_DATA, 8'h00, 8'h00, 1'b0);
        // build 0x7FFF in the current address: fine Y from the scroll path
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_ADDR,   8'h3F, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_SCROLL, 8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_SCROLL, 8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_ADDR,   8'hFF, 8'h00, 1'b0);
        // address wraps to 0
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_DATA,   8'h81, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_READ,  vrst_pkg::REG_DATA,   8'h00, 8'hFF, 1'b1);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_CTRL,   8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_MASK,   8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_READ,  vrst_pkg::REG_DATA,   8'h00, 8'h3C, 1'b0);
        send_item(vrst_pkg::OP_READ,  vrst_pkg::REG_STATUS, 8'h00, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_NMI,   vrst_pkg::REG_CTRL,   8'hFF, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_NMI,   vrst_pkg::REG_CTRL,   8'h00, 8'h00, 1'b0);
        // first dot of line 0 skipped
        send_item(vrst_pkg::OP_DOT,   vrst_pkg::REG_CTRL,   8'h00, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_DOT,   vrst_pkg::REG_CTRL,   8'h00, 8'h00, 1'b0);
    endtask

    // a couple of scanlines, rendering on, with sparse CPU traffic
    task automatic test_scroll_frame();
        vrst_pkg::t_op op;
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_MASK, 8'h18, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_READ,  vrst_pkg::REG_STATUS, 8'h00, 8'h00, 1'b0);
        // coarse Y 30
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_ADDR, 8'h03, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_ADDR, 8'hC0, 8'h00, 1'b0);
        send_item(vrst_pkg::OP_WRITE, vrst_pkg::REG_CTRL, 8'h83, 8'h00, 1'b0);
        for (int n = 0; n < SCROLL_DOTS; n++) begin
            if (line_q > 240 && $urandom_range(999) == 0) begin
                send_random_fields(vrst_pkg::OP_READ);
                send_item(vrst_pkg::OP_READ, vrst_pkg::REG_STATUS, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if ($urandom_range(399) == 0) begin
                op = vrst_pkg::t_op'($urandom_range(1, 3));
                if (op == vrst_pkg::OP_WRITE)
                    send_item(vrst_pkg::OP_WRITE,
                              ($urandom_range(1) != 0) ? vrst_pkg::REG_SCROLL
                                                       : vrst_pkg::REG_DATA,
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                else
                    send_random_fields(op);
            end else begin
                send_random_fields(vrst_pkg::OP_DOT);
            end
        end
    endtask

    task automatic test_random_traffic(input int count);
        int pick;
        logic [2:0] pair_reg;
        for (int n = 0; n < count; n++) begin
            if (n > 0 && n % 200 == 0) wait_results_drained();
            pick = $urandom_range(99);
            if (pick < 12) begin
                // toggle reset then a proper two-byte scroll or address write
                pair_reg = ($urandom_range(1) != 0) ? vrst_pkg::REG_SCROLL : vrst_pkg::REG_ADDR;
                send_item(vrst_pkg::OP_READ, vrst_pkg::REG_STATUS, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
                send_item(vrst_pkg::OP_WRITE, pair_reg, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
                send_item(vrst_pkg::OP_WRITE, pair_reg, 8'($urandom_range(255)),
                          8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 45) begin
                send_random_fields(vrst_pkg::OP_DOT);
            end else if (pick < 65) begin
                send_random_fields(vrst_pkg::OP_READ);
            end else if (pick < 95) begin
                send_random_fields(vrst_pkg::OP_WRITE);
            end else begin
                send_random_fields(vrst_pkg::OP_NMI);
            end
        end
    endtask

    initial begin
        ctrl_q = '0;
        mask_q = '0;
        status_q = '0;
        oam_addr_q = '0;
        rbuf_q = '0;
        vaddr_q = '0;
        taddr_q = '0;
        toggle_q = 1'b1;
        nmi_q = 1'b0;
        line_q = 0;
        dot_q = 0;
        foreach (oam_q[i]) oam_q[i] = '0;

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 71;
        test_reset_state_reads();
        test_register_writes();
        test_random_traffic(300);

        send_idle_pct = 71;
        recv_idle_pct = 28;
        test_random_traffic(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_scroll_frame();
        test_random_traffic(300);

        s_valid <= 1'b0;
        for (int n = 0; n < 5000 && bus_results_due.size() != 0; n++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (bus_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", bus_results_due.size()));

        if (mismatches == 0) begin
            $display("video_register_scroll_timing_unit verification clean");
        end else begin
            $display("video_register_scroll_timing_unit verification failed");
        end
        $finish;
    end

endmodule
